@@ design/tcmc_pkg.sv @@
package tcmc_pkg;

  localparam int unsigned LINE_ADDR_BITS_DEF = 16;
  localparam int unsigned SHADOW_DEPTH_DEF   = 64;
  localparam int unsigned COUNTER_BITS_DEF   = 48;

  localparam int unsigned CFG_BITS = 7;
  localparam logic [CFG_BITS-1:0] SHADOW_LINES_RST = 7'd64;

  // The seen bitmap is stored as rows of 2**SEEN_ROW_LOG bits.
  localparam int unsigned SEEN_ROW_LOG = 5;

  typedef enum logic [1:0] {
    CLS_HIT  = 2'd0,
    CLS_COMP = 2'd1,
    CLS_CAP  = 2'd2,
    CLS_CONF = 2'd3
  } miss_class_e;

  typedef enum logic {
    OP_HIT  = 1'b0,
    OP_MISS = 1'b1
  } op_e;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic scan_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/tcmc_if.sv @@
interface tcmc_evt_if #(
  parameter int unsigned LINE_ADDR_BITS = tcmc_pkg::LINE_ADDR_BITS_DEF
);
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [LINE_ADDR_BITS-1:0] line_id;

  modport source (output valid, operation, line_id, input ready);
  modport sink   (input valid, operation, line_id, output ready);
endinterface

interface tcmc_res_if #(
  parameter int unsigned COUNTER_BITS = tcmc_pkg::COUNTER_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              miss_class;
  logic                    in_shadow;
  logic [COUNTER_BITS-1:0] compulsory_total;
  logic [COUNTER_BITS-1:0] capacity_total;
  logic [COUNTER_BITS-1:0] conflict_total;
  logic [COUNTER_BITS-1:0] miss_total;
  logic [COUNTER_BITS-1:0] hit_total;

  modport source (output valid, miss_class, in_shadow, compulsory_total, capacity_total,
                  conflict_total, miss_total, hit_total, input ready);
  modport sink   (input valid, miss_class, in_shadow, compulsory_total, capacity_total,
                  conflict_total, miss_total, hit_total, output ready);
endinterface

@@ design/tcmc_ctrl.sv @@
module tcmc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tcmc_pkg::dp_status_t status_i,
  output tcmc_pkg::dp_cmd_t    cmd_o
);
  import tcmc_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/tcmc_datapath.sv @@
module tcmc_datapath #(
  parameter int unsigned LINE_ADDR_BITS = tcmc_pkg::LINE_ADDR_BITS_DEF,
  parameter int unsigned SHADOW_DEPTH   = tcmc_pkg::SHADOW_DEPTH_DEF,
  parameter int unsigned COUNTER_BITS   = tcmc_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tcmc_pkg::CFG_BITS-1:0]   cfg_wdata_i,
  input  logic                            in_op_i,
  input  logic [LINE_ADDR_BITS-1:0]       in_addr_i,
  input  tcmc_pkg::dp_cmd_t               cmd_i,
  output tcmc_pkg::dp_status_t            status_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [1:0]                      miss_class_o,
  output logic                            in_shadow_o,
  output logic [COUNTER_BITS-1:0]         compulsory_total_o,
  output logic [COUNTER_BITS-1:0]         capacity_total_o,
  output logic [COUNTER_BITS-1:0]         conflict_total_o,
  output logic [COUNTER_BITS-1:0]         miss_total_o,
  output logic [COUNTER_BITS-1:0]         hit_total_o
);
  import tcmc_pkg::*;

  localparam int unsigned ROW_LOG = SEEN_ROW_LOG;
  localparam int unsigned ROW_W   = 1 << ROW_LOG;
  localparam int unsigned ROW_AW  = LINE_ADDR_BITS - ROW_LOG;
  localparam int unsigned ROWS    = 1 << ROW_AW;
  localparam int unsigned PW      = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;
  localparam int unsigned FW      = $clog2(SHADOW_DEPTH + 1);
  localparam int unsigned DW      = (FW > CFG_BITS) ? FW : CFG_BITS;

  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

  logic [CFG_BITS-1:0]       shadow_lines_q;
  logic [DW-1:0]             lines_ext;
  logic [DW-1:0]             depth_eff;

  logic [ROW_W-1:0]          seen_mem [ROWS];
  logic [ROW_W-1:0]          seen_row_q;
  logic [ROW_W-1:0]          seen_bit;
  logic [ROW_AW-1:0]         clr_idx_q;
  logic                      first_sight;

  logic [LINE_ADDR_BITS-1:0] tag_mem [SHADOW_DEPTH];
  logic [LINE_ADDR_BITS-1:0] tag_rd_q;
  logic [LINE_ADDR_BITS-1:0] held_q;
  logic [LINE_ADDR_BITS-1:0] addr_q;
  logic                      op_q;
  logic [FW-1:0]             pos_q;
  logic [FW-1:0]             pos_nxt;
  logic [FW-1:0]             fill_q;
  logic                      found_q;
  logic                      at_end;
  logic                      match;
  logic                      room;
  logic                      tag_we;
  logic                      tag_re;

  miss_class_e               cls;
  miss_class_e               miss_class_q;
  logic                      in_shadow_q;
  logic                      out_valid_q;
  logic [COUNTER_BITS-1:0]   comp_q, cap_q, conf_q, miss_q, hit_q;

  always_comb begin
    lines_ext = DW'(shadow_lines_q);
    if (lines_ext == '0) begin
      depth_eff = DW'(1);
    end else if (lines_ext > DW'(SHADOW_DEPTH)) begin
      depth_eff = DW'(SHADOW_DEPTH);
    end else begin
      depth_eff = lines_ext;
    end
  end

  assign seen_bit    = ROW_W'(1) << addr_q[ROW_LOG-1:0];
  assign first_sight = ~|(seen_row_q & seen_bit);

  // The shadow keeps its tags ordered by recency, position zero most recent.
  // A walk shifts each tag one place down until the line is found or the end is reached.
  assign at_end  = (pos_q == fill_q);
  assign match   = !at_end && (tag_rd_q == addr_q);
  assign room    = DW'(fill_q) < depth_eff;
  assign pos_nxt = pos_q + 1'b1;
  assign tag_we  = cmd_i.scan_step && (!at_end || room);
  assign tag_re  = cmd_i.scan_step && !at_end && !match && (pos_nxt < fill_q);

  always_comb begin
    if (op_q == OP_HIT) begin
      cls = CLS_HIT;
    end else if (first_sight) begin
      cls = CLS_COMP;
    end else if (!found_q) begin
      cls = CLS_CAP;
    end else begin
      cls = CLS_CONF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      seen_mem[clr_idx_q] <= '0;
    end else if (cmd_i.finish) begin
      seen_mem[addr_q[LINE_ADDR_BITS-1:ROW_LOG]] <= seen_row_q | seen_bit;
    end
    if (cmd_i.capture) begin
      seen_row_q <= seen_mem[in_addr_i[LINE_ADDR_BITS-1:ROW_LOG]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[pos_q[PW-1:0]] <= held_q;
    end
    if (cmd_i.capture) begin
      tag_rd_q <= tag_mem[PW'(0)];
    end else if (tag_re) begin
      tag_rd_q <= tag_mem[pos_nxt[PW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_op_i;
      addr_q <= in_addr_i;
      held_q <= in_addr_i;
    end else if (cmd_i.scan_step && !at_end && !match) begin
      held_q <= tag_rd_q;
    end
    if (cmd_i.finish) begin
      miss_class_q <= cls;
      in_shadow_q  <= found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_lines_q <= SHADOW_LINES_RST;
      clr_idx_q      <= '0;
      pos_q          <= '0;
      fill_q         <= '0;
      found_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      comp_q         <= '0;
      cap_q          <= '0;
      conf_q         <= '0;
      miss_q         <= '0;
      hit_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        shadow_lines_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_step) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (cmd_i.capture) begin
        pos_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (match) begin
          found_q <= 1'b1;
        end else if (!at_end) begin
          pos_q <= pos_nxt;
        end else if (room) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        case (cls)
          CLS_HIT: begin
            hit_q <= sat_inc(hit_q);
          end
          CLS_COMP: begin
            comp_q <= sat_inc(comp_q);
            miss_q <= sat_inc(miss_q);
          end
          CLS_CAP: begin
            cap_q  <= sat_inc(cap_q);
            miss_q <= sat_inc(miss_q);
          end
          CLS_CONF: begin
            conf_q <= sat_inc(conf_q);
            miss_q <= sat_inc(miss_q);
          end
          default: begin
            hit_q <= hit_q;
          end
        endcase
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.clear_last = &clr_idx_q;
  assign status_o.scan_done  = at_end || match;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // The totals only move on a finish, which waits for the result slot to free up.
  assign out_valid_o        = out_valid_q;
  assign miss_class_o       = miss_class_q;
  assign in_shadow_o        = in_shadow_q;
  assign compulsory_total_o = comp_q;
  assign capacity_total_o   = cap_q;
  assign conflict_total_o   = conf_q;
  assign miss_total_o       = miss_q;
  assign hit_total_o        = hit_q;

endmodule

@@ design/three_c_miss_classifier_core.sv @@
// Three-C miss classifier. Each beat on evt_i reports one real-cache event
// (operation 0 hit, 1 miss) on a line address; each event yields exactly one
// beat on res_o with its class, the shadow-cache hit flag and the running
// saturating totals after that event. cfg_we_i writes the shadow depth.
// After reset the seen bitmap is cleared one 32-bit row per cycle, all
// 2**(LINE_ADDR_BITS-5) rows (2048 by default); evt_i.ready stays low until
// then. The shadow starts empty, the depth at 64 and all totals at zero.
// An accepted event is captured, then walked over the shadow tag memory one
// entry per cycle, from recency position zero up to the line on a shadow hit
// or up to the shadow fill on a shadow miss; its result is then registered.
// Only one event is walked at a time, so no new event is taken until the
// walk of the last one has finished and its result has been registered.
// A result waits in its output register while res_o.ready is low; the next
// event may still be taken and walked, and its result holds until the
// pending one is taken.
module three_c_miss_classifier_core #(
  parameter int unsigned LINE_ADDR_BITS = tcmc_pkg::LINE_ADDR_BITS_DEF,
  parameter int unsigned SHADOW_DEPTH   = tcmc_pkg::SHADOW_DEPTH_DEF,
  parameter int unsigned COUNTER_BITS   = tcmc_pkg::COUNTER_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcmc_pkg::CFG_BITS-1:0] cfg_wdata_i,
  tcmc_evt_if.sink                      evt_i,
  tcmc_res_if.source                    res_o
);
  import tcmc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  tcmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (evt_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcmc_datapath #(
    .LINE_ADDR_BITS (LINE_ADDR_BITS),
    .SHADOW_DEPTH   (SHADOW_DEPTH),
    .COUNTER_BITS   (COUNTER_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_op_i            (evt_i.operation),
    .in_addr_i          (evt_i.line_id),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_ready_i        (res_o.ready),
    .out_valid_o        (res_o.valid),
    .miss_class_o       (res_o.miss_class),
    .in_shadow_o        (res_o.in_shadow),
    .compulsory_total_o (res_o.compulsory_total),
    .capacity_total_o   (res_o.capacity_total),
    .conflict_total_o   (res_o.conflict_total),
    .miss_total_o       (res_o.miss_total),
    .hit_total_o        (res_o.hit_total)
  );

  assign evt_i.ready = in_ready;

endmodule

@@ design/tcmc_checker.sv @@
module tcmc_checker #(
  parameter int unsigned COUNTER_BITS = tcmc_pkg::COUNTER_BITS_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    evt_valid_i,
  input logic                    evt_ready_i,
  input logic                    res_valid_i,
  input logic                    res_ready_i,
  input logic [1:0]              miss_class_i,
  input logic                    in_shadow_i,
  input logic [COUNTER_BITS-1:0] compulsory_total_i,
  input logic [COUNTER_BITS-1:0] capacity_total_i,
  input logic [COUNTER_BITS-1:0] conflict_total_i,
  input logic [COUNTER_BITS-1:0] miss_total_i,
  input logic [COUNTER_BITS-1:0] hit_total_i
);
  import tcmc_pkg::*;

  logic                  evt_beat;
  logic                  res_beat;
  logic [1:0]            pend_q, pend_d;
  logic [COUNTER_BITS+1:0] class_sum;

  assign evt_beat  = evt_valid_i && evt_ready_i;
  assign res_beat  = res_valid_i && res_ready_i;
  assign pend_d    = pend_q + 2'(evt_beat) - 2'(res_beat);
  assign class_sum = (COUNTER_BITS+2)'(compulsory_total_i) + (COUNTER_BITS+2)'(capacity_total_i)
                   + (COUNTER_BITS+2)'(conflict_total_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable({miss_class_i, in_shadow_i, compulsory_total_i,
      capacity_total_i, conflict_total_i, miss_total_i, hit_total_i}))
    else $error("result beat changed while stalled");

  a_miss_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !(&miss_total_i) |-> class_sum == (COUNTER_BITS+2)'(miss_total_i))
    else $error("miss total differs from the sum of the classes");

  a_cold_not_shadow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (miss_class_i == CLS_COMP || miss_class_i == CLS_CAP) |-> !in_shadow_i)
    else $error("compulsory or capacity miss with a shadow hit");

  a_conf_shadow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && miss_class_i == CLS_CONF |-> in_shadow_i)
    else $error("conflict miss without a shadow hit");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_beat |-> pend_q != 2'd0)
    else $error("result beat without an outstanding event");

endmodule

bind three_c_miss_classifier_core tcmc_checker #(
  .COUNTER_BITS (COUNTER_BITS)
) u_tcmc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .evt_valid_i        (evt_i.valid),
  .evt_ready_i        (evt_i.ready),
  .res_valid_i        (res_o.valid),
  .res_ready_i        (res_o.ready),
  .miss_class_i       (res_o.miss_class),
  .in_shadow_i        (res_o.in_shadow),
  .compulsory_total_i (res_o.compulsory_total),
  .capacity_total_i   (res_o.capacity_total),
  .conflict_total_i   (res_o.conflict_total),
  .miss_total_i       (res_o.miss_total),
  .hit_total_i        (res_o.hit_total)
);
